@@ design/rti_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and helpers for the ray/triangle intersection unit.
// No dependencies; every other design file refers to it by scoped names.
package rti_pkg;

	// fixed-point formats
	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS   = 8;
	localparam int SLOT_W      = 16;
	localparam int CW          = (COORD_WIDTH < SLOT_W) ? COORD_WIDTH : SLOT_W;
	localparam int REG_W       = 48;
	localparam int IDX_W       = 2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_CORNER_ZERO = 2'd0;
	localparam logic [IDX_W-1:0] REG_CORNER_ONE  = 2'd1;
	localparam logic [IDX_W-1:0] REG_CORNER_TWO  = 2'd2;

	// determinant datapath widths
	localparam int DIFF_W = CW + 1;
	localparam int PR_W   = 2 * DIFF_W;
	localparam int C_W    = PR_W + 1;
	localparam int P2_W   = DIFF_W + C_W;
	localparam int S_W    = P2_W + 2;
	localparam int DEN_W  = S_W;

	// distance division
	localparam int FRAC_OUT  = 16;
	localparam int DIV_STEPS = 31;
	localparam int NUM_LOW   = DIV_STEPS - FRAC_OUT;
	localparam int M_W       = SLOT_W + FRAC_OUT - FRAC_BITS;
	localparam int DIST_W    = 32;
	localparam int T_W       = DIST_W + 2;
	localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

	// normal unit
	localparam int NC_W       = 2 * DIFF_W + 1;
	localparam int NM_W       = 31;
	localparam int NORM_FRAC  = 14;
	localparam int NQ_BITS    = NORM_FRAC + 1;
	localparam int NN_W       = NM_W + NORM_FRAC + 1;
	localparam int ROOT_W     = 64;
	localparam int NORM_W     = 32;
	localparam int ROOT_STEPS = 32;
	localparam int STEP_W     = $clog2(ROOT_STEPS);
	localparam int SH_MAX     = (NC_W > NM_W) ? (NC_W - NM_W) : 0;
	localparam int SH_W       = (SH_MAX > 0) ? $clog2(SH_MAX + 1) : 1;
	localparam int NRM_W      = 16;

	typedef struct packed {
		logic signed [SLOT_W-1:0] origin_x;
		logic signed [SLOT_W-1:0] origin_y;
		logic signed [SLOT_W-1:0] origin_z;
		logic signed [SLOT_W-1:0] dir_x;
		logic signed [SLOT_W-1:0] dir_y;
		logic signed [SLOT_W-1:0] dir_z;
		logic signed [SLOT_W-1:0] min_distance;
	} ray_in_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DIST_W-1:0] distance;
		logic signed [NRM_W-1:0]  normal_x;
		logic signed [NRM_W-1:0]  normal_y;
		logic signed [NRM_W-1:0]  normal_z;
	} ray_out_t;

	// one beat of the distance divider
	typedef struct packed {
		logic                    miss;
		logic                    big;
		logic                    tneg;
		logic signed [M_W-1:0]   m16;
		logic [DEN_W-1:0]        den;
		logic [DEN_W-1:0]        rem;
		logic [DIV_STEPS-1:0]    feed;
		logic [DIV_STEPS-1:0]    quo;
	} div_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] x;
		logic signed [NRM_W-1:0] y;
		logic signed [NRM_W-1:0] z;
	} normal_t;

	typedef enum logic [2:0] {
		NS_IDLE,
		NS_CROSS,
		NS_SCALE,
		NS_SQUARE,
		NS_ROOT,
		NS_DIVIDE
	} norm_state_t;

	// low CW bits of a slot as a signed coordinate
	function automatic logic signed [CW-1:0] sext(input logic [SLOT_W-1:0] v);
		return $signed(v[CW-1:0]);
	endfunction

endpackage

@@ design/ray_triangle_intersect_unit.sv @@
`timescale 1ns / 1ps
// Ray/triangle intersection unit, top level: corner registers, front
// pipeline, distance divider, normal unit and output register.
// Depends on rti_pkg, rti_front, rti_div and rti_norm.
//
// Accepts one ray per clock while in_stall is low and returns one result
// per ray, in order, after 7 determinant stages, 31 divider stages and one
// output register; the 31-stage distance divider sets the depth. Stalls
// at the output back up stage by stage, so empty stages still take rays.
// Each configuration write restarts the normal unit (cross product,
// scaling, three squares, 32 square-root steps, three 16-step divisions);
// input beats are stalled while it runs. Write the corners only while no
// ray is in flight.
module ray_triangle_intersect_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  rti_pkg::ray_in_t          in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output rti_pkg::ray_out_t         out_data,
	input  logic                      cfg_we,
	input  logic [rti_pkg::IDX_W-1:0] cfg_index,
	input  logic [rti_pkg::REG_W-1:0] cfg_data
);

	localparam int TW = rti_pkg::T_W;
	localparam int DT = rti_pkg::DIST_W;

	logic [rti_pkg::REG_W-1:0] corner0_q, corner1_q, corner2_q;

	logic          fr_ready, fr_valid, dv_valid, dv_ready, dv_in_ready;
	rti_pkg::div_t fr_data, dv_data;
	logic          nrm_busy;
	rti_pkg::normal_t nrm;

	rti_pkg::ray_out_t out_q;
	logic              out_vld_q;

	logic signed [TW-1:0] tmag, m16e, negm;
	logic                 ok_pos, ok_neg, hit_n;
	rti_pkg::ray_out_t    res_n;

	// corner registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner0_q <= '0;
			corner1_q <= '0;
			corner2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rti_pkg::REG_CORNER_ZERO: corner0_q <= cfg_data;
				rti_pkg::REG_CORNER_ONE:  corner1_q <= cfg_data;
				rti_pkg::REG_CORNER_TWO:  corner2_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// hold off rays while the corners change or the normal is rebuilt
	assign in_stall = !fr_ready || nrm_busy || cfg_we;

	rti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid && !nrm_busy && !cfg_we),
		.in_ready  (fr_ready),
		.in_data   (in_data),
		.corner0   (corner0_q),
		.corner1   (corner1_q),
		.corner2   (corner2_q),
		.out_valid (fr_valid),
		.out_ready (dv_in_ready),
		.out_data  (fr_data)
	);

	rti_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (dv_in_ready),
		.in_data   (fr_data),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_data  (dv_data)
	);

	rti_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cfg_we),
		.corner0 (corner0_q),
		.corner1 (corner1_q),
		.corner2 (corner2_q),
		.busy    (nrm_busy),
		.normal  (nrm)
	);

	// distance test against the minimum, saturation and result assembly
	always_comb begin
		tmag   = $signed(TW'({1'b0, dv_data.quo}));
		m16e   = TW'(dv_data.m16);
		negm   = -m16e;
		ok_pos = dv_data.big || (tmag >= m16e);
		ok_neg = !dv_data.big && ((tmag < negm) || (tmag == negm && dv_data.rem == '0));
		hit_n  = !dv_data.miss && (dv_data.tneg ? ok_neg : ok_pos);
		res_n  = '0;
		if (hit_n) begin
			res_n.hit = 1'b1;
			if (dv_data.big)
				res_n.distance = dv_data.tneg ? rti_pkg::DIST_MIN : rti_pkg::DIST_MAX;
			else
				res_n.distance = dv_data.tneg ? DT'(-tmag) : DT'(tmag);
			res_n.normal_x = nrm.x;
			res_n.normal_y = nrm.y;
			res_n.normal_z = nrm.z;
		end
	end

	// output register
	assign dv_ready = !out_vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (dv_ready) begin
			out_vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_ready) out_q <= res_n;
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

@@ design/rti_front.sv @@
`timescale 1ns / 1ps
// Front of the intersection pipeline: Cramer determinants, sign fix-up,
// barycentric range tests and divider set-up. Depends on rti_pkg.
module rti_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rti_pkg::ray_in_t            in_data,
	input  logic [rti_pkg::REG_W-1:0]   corner0,
	input  logic [rti_pkg::REG_W-1:0]   corner1,
	input  logic [rti_pkg::REG_W-1:0]   corner2,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rti_pkg::div_t               out_data
);

	localparam int DW = rti_pkg::DIFF_W;
	localparam int PW = rti_pkg::PR_W;
	localparam int CWD = rti_pkg::C_W;
	localparam int QW = rti_pkg::P2_W;
	localparam int SW = rti_pkg::S_W;
	localparam int MW = rti_pkg::M_W;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7;

	// stage 1..3 operands
	logic signed [DW-1:0] a_s1, b_s1, c_s1, d_s1, e_s1, f_s1;
	logic signed [DW-1:0] g_s1, h_s1, i_s1, j_s1, k_s1, l_s1;
	logic signed [DW-1:0] a_s2, b_s2, c_s2, d_s2, e_s2, f_s2;
	logic signed [DW-1:0] g_s2, h_s2, i_s2, j_s2, k_s2, l_s2;
	logic signed [DW-1:0] a_s3, b_s3, c_s3, d_s3, e_s3, f_s3;
	logic signed [DW-1:0] g_s3, h_s3, i_s3, j_s3, k_s3, l_s3;
	logic signed [MW-1:0] m16_s1, m16_s2, m16_s3, m16_s4, m16_s5, m16_s6;

	logic signed [PW-1:0] pei_s2, phf_s2, pgf_s2, pdi_s2, pdh_s2, peg_s2;
	logic signed [PW-1:0] pak_s2, pjb_s2, pjc_s2, pal_s2, pbl_s2, pkc_s2;
	logic signed [CWD-1:0] c1_s3, c2_s3, c3_s3, c4_s3, c5_s3, c6_s3;
	logic signed [QW-1:0] ac1_s4, bc2_s4, cc3_s4, fc4_s4, ec5_s4, dc6_s4;
	logic signed [QW-1:0] ic4_s4, hc5_s4, gc6_s4, jc1_s4, kc2_s4, lc3_s4;
	logic signed [SW-1:0] det_s5, nt_s5, ng_s5, nb_s5;
	logic signed [SW-1:0] den_s6, tn_s6, ng_s6, nb_s6;
	logic                 zero_s6;
	rti_pkg::div_t        div_s7;

	logic signed [rti_pkg::CW-1:0] p0x, p0y, p0z, p1x, p1y, p1z, p2x, p2y, p2z;
	logic signed [SW-1:0]          den_n, tn_n, ng_n, nb_n;
	logic signed [SW:0]            gb_sum;
	logic [rti_pkg::DEN_W-1:0]     num_n, den_u;
	rti_pkg::div_t                 div_n;

	// stage hand-off: a stage loads when empty or when its successor moves
	always_comb begin
		adv_s7 = !vld_s7 || out_ready;
		adv_s6 = !vld_s6 || adv_s7;
		adv_s5 = !vld_s5 || adv_s6;
		adv_s4 = !vld_s4 || adv_s5;
		adv_s3 = !vld_s3 || adv_s4;
		adv_s2 = !vld_s2 || adv_s3;
		adv_s1 = !vld_s1 || adv_s2;
	end

	assign in_ready  = adv_s1;
	assign out_valid = vld_s7;
	assign out_data  = div_s7;

	// corner coordinates
	always_comb begin
		p0x = rti_pkg::sext(corner0[47:32]);
		p0y = rti_pkg::sext(corner0[31:16]);
		p0z = rti_pkg::sext(corner0[15:0]);
		p1x = rti_pkg::sext(corner1[47:32]);
		p1y = rti_pkg::sext(corner1[31:16]);
		p1z = rti_pkg::sext(corner1[15:0]);
		p2x = rti_pkg::sext(corner2[47:32]);
		p2y = rti_pkg::sext(corner2[31:16]);
		p2z = rti_pkg::sext(corner2[15:0]);
	end

	// stage 6: make the determinant positive, t = tn / det
	always_comb begin
		if (det_s5 < 0) begin
			den_n = -det_s5;
			tn_n  = nt_s5;
			ng_n  = -ng_s5;
			nb_n  = -nb_s5;
		end else begin
			den_n = det_s5;
			tn_n  = -nt_s5;
			ng_n  = ng_s5;
			nb_n  = nb_s5;
		end
	end

	// stage 7: range tests and divider set-up
	always_comb begin
		gb_sum = (SW+1)'(ng_s6) + (SW+1)'(nb_s6);
		num_n  = rti_pkg::DEN_W'((tn_s6 < 0) ? -tn_s6 : tn_s6);
		den_u  = rti_pkg::DEN_W'(den_s6);
		div_n.miss = zero_s6 || (ng_s6 < 0) || (ng_s6 > den_s6) || (nb_s6 < 0)
			|| (gb_sum > (SW+1)'(den_s6));
		div_n.big  = (num_n >> rti_pkg::NUM_LOW) >= den_u;
		div_n.tneg = tn_s6 < 0;
		div_n.m16  = m16_s6;
		div_n.den  = den_u;
		div_n.rem  = num_n >> rti_pkg::NUM_LOW;
		div_n.feed = {num_n[rti_pkg::NUM_LOW-1:0], rti_pkg::FRAC_OUT'(0)};
		div_n.quo  = '0;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
			if (adv_s7) vld_s7 <= vld_s6;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		// stage 1: edge and offset vectors
		if (adv_s1) begin
			a_s1 <= DW'(p0x) - DW'(p1x);
			b_s1 <= DW'(p0y) - DW'(p1y);
			c_s1 <= DW'(p0z) - DW'(p1z);
			d_s1 <= DW'(p0x) - DW'(p2x);
			e_s1 <= DW'(p0y) - DW'(p2y);
			f_s1 <= DW'(p0z) - DW'(p2z);
			g_s1 <= DW'(rti_pkg::sext(in_data.dir_x));
			h_s1 <= DW'(rti_pkg::sext(in_data.dir_y));
			i_s1 <= DW'(rti_pkg::sext(in_data.dir_z));
			j_s1 <= DW'(p0x) - DW'(rti_pkg::sext(in_data.origin_x));
			k_s1 <= DW'(p0y) - DW'(rti_pkg::sext(in_data.origin_y));
			l_s1 <= DW'(p0z) - DW'(rti_pkg::sext(in_data.origin_z));
			m16_s1 <= MW'(rti_pkg::sext(in_data.min_distance))
				<<< (rti_pkg::FRAC_OUT - rti_pkg::FRAC_BITS);
		end
		// stage 2: first products
		if (adv_s2) begin
			pei_s2 <= PW'(e_s1) * PW'(i_s1);
			phf_s2 <= PW'(h_s1) * PW'(f_s1);
			pgf_s2 <= PW'(g_s1) * PW'(f_s1);
			pdi_s2 <= PW'(d_s1) * PW'(i_s1);
			pdh_s2 <= PW'(d_s1) * PW'(h_s1);
			peg_s2 <= PW'(e_s1) * PW'(g_s1);
			pak_s2 <= PW'(a_s1) * PW'(k_s1);
			pjb_s2 <= PW'(j_s1) * PW'(b_s1);
			pjc_s2 <= PW'(j_s1) * PW'(c_s1);
			pal_s2 <= PW'(a_s1) * PW'(l_s1);
			pbl_s2 <= PW'(b_s1) * PW'(l_s1);
			pkc_s2 <= PW'(k_s1) * PW'(c_s1);
			a_s2 <= a_s1; b_s2 <= b_s1; c_s2 <= c_s1; d_s2 <= d_s1;
			e_s2 <= e_s1; f_s2 <= f_s1; g_s2 <= g_s1; h_s2 <= h_s1;
			i_s2 <= i_s1; j_s2 <= j_s1; k_s2 <= k_s1; l_s2 <= l_s1;
			m16_s2 <= m16_s1;
		end
		// stage 3: 2x2 minors
		if (adv_s3) begin
			c1_s3 <= CWD'(pei_s2) - CWD'(phf_s2);
			c2_s3 <= CWD'(pgf_s2) - CWD'(pdi_s2);
			c3_s3 <= CWD'(pdh_s2) - CWD'(peg_s2);
			c4_s3 <= CWD'(pak_s2) - CWD'(pjb_s2);
			c5_s3 <= CWD'(pjc_s2) - CWD'(pal_s2);
			c6_s3 <= CWD'(pbl_s2) - CWD'(pkc_s2);
			a_s3 <= a_s2; b_s3 <= b_s2; c_s3 <= c_s2; d_s3 <= d_s2;
			e_s3 <= e_s2; f_s3 <= f_s2; g_s3 <= g_s2; h_s3 <= h_s2;
			i_s3 <= i_s2; j_s3 <= j_s2; k_s3 <= k_s2; l_s3 <= l_s2;
			m16_s3 <= m16_s2;
		end
		// stage 4: second products
		if (adv_s4) begin
			ac1_s4 <= QW'(a_s3) * QW'(c1_s3);
			bc2_s4 <= QW'(b_s3) * QW'(c2_s3);
			cc3_s4 <= QW'(c_s3) * QW'(c3_s3);
			fc4_s4 <= QW'(f_s3) * QW'(c4_s3);
			ec5_s4 <= QW'(e_s3) * QW'(c5_s3);
			dc6_s4 <= QW'(d_s3) * QW'(c6_s3);
			ic4_s4 <= QW'(i_s3) * QW'(c4_s3);
			hc5_s4 <= QW'(h_s3) * QW'(c5_s3);
			gc6_s4 <= QW'(g_s3) * QW'(c6_s3);
			jc1_s4 <= QW'(j_s3) * QW'(c1_s3);
			kc2_s4 <= QW'(k_s3) * QW'(c2_s3);
			lc3_s4 <= QW'(l_s3) * QW'(c3_s3);
			m16_s4 <= m16_s3;
		end
		// stage 5: determinant and numerators
		if (adv_s5) begin
			det_s5 <= SW'(ac1_s4) + SW'(bc2_s4) + SW'(cc3_s4);
			nt_s5  <= SW'(fc4_s4) + SW'(ec5_s4) + SW'(dc6_s4);
			ng_s5  <= SW'(ic4_s4) + SW'(hc5_s4) + SW'(gc6_s4);
			nb_s5  <= SW'(jc1_s4) + SW'(kc2_s4) + SW'(lc3_s4);
			m16_s5 <= m16_s4;
		end
		if (adv_s6) begin
			den_s6  <= den_n;
			tn_s6   <= tn_n;
			ng_s6   <= ng_n;
			nb_s6   <= nb_n;
			zero_s6 <= det_s5 == '0;
			m16_s6  <= m16_s5;
		end
		if (adv_s7) begin
			div_s7 <= div_n;
		end
	end

endmodule

@@ design/rti_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider for the ray distance, one quotient bit a stage.
// Depends on rti_pkg (div_t beat layout).
module rti_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rti_pkg::div_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rti_pkg::div_t out_data
);

	localparam int N  = rti_pkg::DIV_STEPS;
	localparam int DN = rti_pkg::DEN_W;

	rti_pkg::div_t step_s [N];
	logic          vld_s  [N];
	logic          adv    [N];
	logic          vin    [N];
	rti_pkg::div_t src    [N];
	rti_pkg::div_t nxt    [N];

	// hand-off chain, tail first
	always_comb begin
		adv[N-1] = !vld_s[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_s[N-1];
	assign out_data  = step_s[N-1];

	// one shift-subtract per stage
	always_comb begin
		logic [DN:0] trial;
		src[0] = in_data;
		vin[0] = in_valid;
		for (int k = 1; k < N; k++) begin
			src[k] = step_s[k-1];
			vin[k] = vld_s[k-1];
		end
		for (int k = 0; k < N; k++) begin
			trial          = {src[k].rem, src[k].feed[N-1]};
			nxt[k]         = src[k];
			nxt[k].feed    = src[k].feed << 1;
			if (trial >= {1'b0, src[k].den}) begin
				nxt[k].rem = DN'(trial - {1'b0, src[k].den});
				nxt[k].quo = {src[k].quo[N-2:0], 1'b1};
			end else begin
				nxt[k].rem = trial[DN-1:0];
				nxt[k].quo = {src[k].quo[N-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) vld_s[k] <= 1'b0;
		end else begin
			for (int k = 0; k < N; k++) begin
				if (adv[k]) vld_s[k] <= vin[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			if (adv[k]) step_s[k] <= nxt[k];
		end
	end

endmodule

@@ design/rti_norm.sv @@
`timescale 1ns / 1ps
// Sequential unit for the triangle's unit normal: cross product, scaling,
// integer square root and per-component division. Depends on rti_pkg.
module rti_norm (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rti_pkg::REG_W-1:0] corner0,
	input  logic [rti_pkg::REG_W-1:0] corner1,
	input  logic [rti_pkg::REG_W-1:0] corner2,
	output logic                      busy,
	output rti_pkg::normal_t          normal
);

	localparam int DW = rti_pkg::DIFF_W;
	localparam int NC = rti_pkg::NC_W;
	localparam int NM = rti_pkg::NM_W;
	localparam int RW = rti_pkg::ROOT_W;
	localparam int NW = rti_pkg::NORM_W;
	localparam int NQ = rti_pkg::NQ_BITS;
	localparam int NN = rti_pkg::NN_W;
	localparam int SL = rti_pkg::SLOT_W;

	rti_pkg::norm_state_t state_q, state_n;
	logic [rti_pkg::STEP_W-1:0] step_q;
	logic [1:0]                 comp_q;

	logic signed [NC-1:0] n_q   [3];
	logic [NM-1:0]        nm_q  [3];
	logic [RW-1:0]        sum_q, root_q, bit_q;
	logic [NW-1:0]        drem_q;
	logic [NQ-1:0]        dfeed_q, dquo_q;
	logic signed [rti_pkg::NRM_W-1:0] nrm_q [3];

	logic signed [DW-1:0] u [3], v [3];
	logic [NC-1:0]        mag [3];
	logic [NC-1:0]        mx;
	logic [rti_pkg::SH_W-1:0] sh;
	logic [RW-1:0]        sq, cand;
	logic [NW-1:0]        norm;
	logic [NN-1:0]        nnum;
	logic [NW:0]          trial;
	logic                 qbit;
	logic [NQ-1:0]        quo_f;
	logic signed [rti_pkg::NRM_W-1:0] rs;

	// edge vectors from corner zero
	always_comb begin
		for (int q = 0; q < 3; q++) begin
			u[q] = DW'(rti_pkg::sext(corner1[rti_pkg::REG_W-1-SL*q -: SL]))
				- DW'(rti_pkg::sext(corner0[rti_pkg::REG_W-1-SL*q -: SL]));
			v[q] = DW'(rti_pkg::sext(corner2[rti_pkg::REG_W-1-SL*q -: SL]))
				- DW'(rti_pkg::sext(corner0[rti_pkg::REG_W-1-SL*q -: SL]));
		end
	end

	// magnitudes, largest one and the shift that brings all below 2^31
	always_comb begin
		mx = '0;
		for (int q = 0; q < 3; q++) begin
			mag[q] = NC'((n_q[q] < 0) ? -n_q[q] : n_q[q]);
			if (mag[q] > mx) mx = mag[q];
		end
		sh = '0;
		for (int s = rti_pkg::SH_MAX; s >= 0; s--) begin
			if (((mx >> s) >> NM) == '0) sh = rti_pkg::SH_W'(s);
		end
	end

	// square, root step and division step
	always_comb begin
		sq    = RW'(nm_q[step_q[1:0]]) * RW'(nm_q[step_q[1:0]]);
		cand  = root_q + bit_q;
		norm  = root_q[NW-1:0];
		nnum  = (NN'(nm_q[comp_q]) << rti_pkg::NORM_FRAC) + NN'(norm >> 1);
		trial = {drem_q, dfeed_q[NQ-1]};
		qbit  = trial >= {1'b0, norm};
		quo_f = {dquo_q[NQ-2:0], qbit};
		rs    = (norm == '0) ? '0 : rti_pkg::NRM_W'(quo_f);
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			rti_pkg::NS_IDLE:   state_n = rti_pkg::NS_IDLE;
			rti_pkg::NS_CROSS:  state_n = rti_pkg::NS_SCALE;
			rti_pkg::NS_SCALE:  state_n = rti_pkg::NS_SQUARE;
			rti_pkg::NS_SQUARE: if (step_q == rti_pkg::STEP_W'(2)) state_n = rti_pkg::NS_ROOT;
			rti_pkg::NS_ROOT: begin
				if (step_q == rti_pkg::STEP_W'(rti_pkg::ROOT_STEPS - 1))
					state_n = rti_pkg::NS_DIVIDE;
			end
			rti_pkg::NS_DIVIDE: begin
				if (step_q == rti_pkg::STEP_W'(NQ) && comp_q == 2'd2)
					state_n = rti_pkg::NS_IDLE;
			end
			default: state_n = rti_pkg::NS_IDLE;
		endcase
		if (start) state_n = rti_pkg::NS_CROSS;
	end

	// outputs
	always_comb begin
		busy     = state_q != rti_pkg::NS_IDLE;
		normal.x = nrm_q[0];
		normal.y = nrm_q[1];
		normal.z = nrm_q[2];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rti_pkg::NS_IDLE;
			step_q  <= '0;
			comp_q  <= '0;
			for (int q = 0; q < 3; q++) nrm_q[q] <= '0;
		end else begin
			state_q <= state_n;
			if (start) begin
				step_q <= '0;
				comp_q <= '0;
			end else begin
				case (state_q)
					rti_pkg::NS_SQUARE: begin
						step_q <= (step_q == rti_pkg::STEP_W'(2)) ? '0 : step_q + 1'b1;
					end
					rti_pkg::NS_ROOT: step_q <= step_q + 1'b1;
					rti_pkg::NS_DIVIDE: begin
						if (step_q == rti_pkg::STEP_W'(NQ)) begin
							nrm_q[comp_q] <= (n_q[comp_q] < 0) ? -rs : rs;
							step_q <= '0;
							comp_q <= comp_q + 1'b1;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
					default: step_q <= '0;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			rti_pkg::NS_CROSS: begin
				n_q[0] <= NC'(u[1]) * NC'(v[2]) - NC'(u[2]) * NC'(v[1]);
				n_q[1] <= NC'(u[2]) * NC'(v[0]) - NC'(u[0]) * NC'(v[2]);
				n_q[2] <= NC'(u[0]) * NC'(v[1]) - NC'(u[1]) * NC'(v[0]);
			end
			rti_pkg::NS_SCALE: begin
				for (int q = 0; q < 3; q++) nm_q[q] <= NM'(mag[q] >> sh);
				sum_q  <= '0;
				root_q <= '0;
				bit_q  <= RW'(1) << (RW - 2);
			end
			rti_pkg::NS_SQUARE: sum_q <= sum_q + sq;
			rti_pkg::NS_ROOT: begin
				if (sum_q >= cand) begin
					sum_q  <= sum_q - cand;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			rti_pkg::NS_DIVIDE: begin
				if (step_q == '0) begin
					drem_q  <= NW'(nnum >> NQ);
					dfeed_q <= nnum[NQ-1:0];
					dquo_q  <= '0;
				end else begin
					drem_q  <= qbit ? NW'(trial - {1'b0, norm}) : trial[NW-1:0];
					dfeed_q <= dfeed_q << 1;
					dquo_q  <= quo_f;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
